// ----- sv/ppm_image_stream_parser_core_assert.svh -----
// Assertion macros used by the PPM stream parser top level.
`ifndef PPM_IMAGE_STREAM_PARSER_CORE_ASSERT_SVH
`define PPM_IMAGE_STREAM_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PPM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppm parser assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppm parser assertion failed");

`endif

// ----- sv/ppm_isp_pkg.sv -----
// Types and constants of the PPM stream parser.
package ppm_isp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned NUM_W    = 16;
  localparam int unsigned MUL_W    = NUM_W + 4;

  localparam logic [NUM_W-1:0] SAT_MAX     = 16'hFFFF;
  localparam logic [NUM_W-1:0] LIMIT_RESET = 16'd1023;

  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
  localparam logic [BYTE_W-1:0] CH_THREE = 8'h33;
  localparam logic [BYTE_W-1:0] CH_SIX   = 8'h36;

  typedef enum logic [8:0] {
    PH_WAIT   = 9'b000000001,
    PH_MAGIC2 = 9'b000000010,
    PH_WIDTH  = 9'b000000100,
    PH_HEIGHT = 9'b000001000,
    PH_MAXVAL = 9'b000010000,
    PH_PLAIN  = 9'b000100000,
    PH_RAW    = 9'b001000000,
    PH_DONE   = 9'b010000000,
    PH_ERROR  = 9'b100000000
  } phase_t;

  typedef enum logic [1:0] {
    K_HEADER = 2'd0,
    K_PIXEL  = 2'd1,
    K_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_MAGIC  = 2'd0,
    ERR_JUNK   = 2'd1,
    ERR_MAXVAL = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    CHAN_R = 2'd0,
    CHAN_G = 2'd1,
    CHAN_B = 2'd2
  } chan_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              frame_start;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    phase_t            phase;
    logic [BYTE_W-1:0] first_magic;
    logic [NUM_W-1:0]  acc;
    logic              in_num;
    logic [NUM_W-1:0]  img_w;
    logic [NUM_W-1:0]  img_h;
    logic [NUM_W-1:0]  maxval;
    logic              raw_mode;
    logic [NUM_W-1:0]  col;
    logic [NUM_W-1:0]  row;
    chan_t             chan;
    logic [NUM_W-1:0]  held_r;
    logic [NUM_W-1:0]  held_g;
  } parse_state_t;

  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic [NUM_W-1:0] red;
    logic [NUM_W-1:0] green;
    logic [NUM_W-1:0] blue;
    logic [NUM_W-1:0] column;
    logic [NUM_W-1:0] row_index;
    logic [NUM_W-1:0] width;
    logic [NUM_W-1:0] height;
    logic [NUM_W-1:0] max_sample;
    logic             raw_format;
    err_t             error_code;
    logic             image_done;
  } result_t;

endpackage

// ----- sv/ppm_isp_if.sv -----
// Valid/ready channel interfaces of the PPM stream parser.
interface ppm_isp_in_if import ppm_isp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              frame_start;
  logic              last_byte;

  modport source (output valid, in_byte, frame_start, last_byte, input ready);
  modport sink   (input valid, in_byte, frame_start, last_byte, output ready);
endinterface

interface ppm_isp_out_if import ppm_isp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [NUM_W-1:0] red;
  logic [NUM_W-1:0] green;
  logic [NUM_W-1:0] blue;
  logic [NUM_W-1:0] column;
  logic [NUM_W-1:0] row_index;
  logic [NUM_W-1:0] width;
  logic [NUM_W-1:0] height;
  logic [NUM_W-1:0] max_sample;
  logic             raw_format;
  logic [1:0]       error_code;
  logic             image_done;

  modport source (output valid, kind, red, green, blue, column, row_index, width, height,
                  max_sample, raw_format, error_code, image_done, input ready);
  modport sink   (input valid, kind, red, green, blue, column, row_index, width, height,
                  max_sample, raw_format, error_code, image_done, output ready);
endinterface

interface ppm_isp_cfg_if import ppm_isp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] max_maxval_limit;

  modport source (output valid, max_maxval_limit, input ready);
  modport sink   (input valid, max_maxval_limit, output ready);
endinterface

// ----- sv/ppm_isp_step.sv -----
// Next-state and result logic for one byte of the PPM stream.
module ppm_isp_step import ppm_isp_pkg::*; (
  input  parse_state_t     st,
  input  in_item_t         item,
  input  logic [NUM_W-1:0] limit,
  output parse_state_t     st_nxt,
  output result_t          res
);

  logic [BYTE_W-1:0] b;
  logic              digit;
  logic              ws;
  logic [NUM_W-1:0]  dval;
  logic [MUL_W-1:0]  acc_mul;
  logic [NUM_W-1:0]  acc_sat;
  logic              num_fire;
  logic [NUM_W-1:0]  num_val;
  logic              pix_fire;
  logic [NUM_W-1:0]  pix_b;
  logic [NUM_W:0]    col_inc;
  logic [NUM_W:0]    row_inc;

  assign b     = item.in_byte;
  assign digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign ws    = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  assign dval  = {{(NUM_W-BYTE_W){1'b0}}, b - CH_ZERO};

  // acc*10 + digit as shifts and adds, then clamp
  assign acc_mul = ({st.acc, 3'b000} + {2'b00, st.acc, 1'b0}) + {4'b0000, dval};
  assign acc_sat = (acc_mul[MUL_W-1:NUM_W] != '0) ? SAT_MAX : acc_mul[NUM_W-1:0];

  assign col_inc = {1'b0, st.col} + 1'b1;
  assign row_inc = {1'b0, st.row} + 1'b1;

  always_comb begin
    st_nxt   = st;
    res      = '0;
    num_fire = 1'b0;
    num_val  = '0;
    pix_fire = 1'b0;
    pix_b    = '0;

    if (item.frame_start) begin
      st_nxt             = '0;
      st_nxt.phase       = PH_MAGIC2;
      st_nxt.first_magic = b;
      st_nxt.chan        = CHAN_R;
    end else begin
      unique case (st.phase)
        PH_MAGIC2: begin
          if (st.first_magic == CH_P && b == CH_THREE) begin
            st_nxt.raw_mode = 1'b0;
            st_nxt.phase    = PH_WIDTH;
          end else if (st.first_magic == CH_P && b == CH_SIX) begin
            st_nxt.raw_mode = 1'b1;
            st_nxt.phase    = PH_WIDTH;
          end else begin
            st_nxt.phase   = PH_ERROR;
            res.valid      = 1'b1;
            res.kind       = K_ERROR;
            res.error_code = ERR_MAGIC;
          end
        end
        PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PLAIN: begin
          if (st.in_num) begin
            if (digit) begin
              st_nxt.acc = acc_sat;
            end else begin
              st_nxt.in_num = 1'b0;
              num_fire      = 1'b1;
              num_val       = st.acc;
            end
          end else if (digit) begin
            st_nxt.in_num = 1'b1;
            st_nxt.acc    = dval;
          end else if (!ws) begin
            st_nxt.phase   = PH_ERROR;
            res.valid      = 1'b1;
            res.kind       = K_ERROR;
            res.error_code = ERR_JUNK;
          end
          // last byte closes a pending number
          if (item.last_byte && st_nxt.in_num) begin
            st_nxt.in_num = 1'b0;
            num_fire      = 1'b1;
            num_val       = st_nxt.acc;
          end
        end
        PH_RAW: begin
          unique case (st.chan)
            CHAN_R: begin
              st_nxt.held_r = {{(NUM_W-BYTE_W){1'b0}}, b};
              st_nxt.chan   = CHAN_G;
            end
            CHAN_G: begin
              st_nxt.held_g = {{(NUM_W-BYTE_W){1'b0}}, b};
              st_nxt.chan   = CHAN_B;
            end
            default: begin
              st_nxt.chan = CHAN_R;
              pix_fire    = 1'b1;
              pix_b       = {{(NUM_W-BYTE_W){1'b0}}, b};
            end
          endcase
        end
        default: ;
      endcase
    end

    // a finished decimal number, used by phase
    if (num_fire) begin
      st_nxt.acc = '0;
      unique case (st.phase)
        PH_WIDTH: begin
          st_nxt.img_w = num_val;
          st_nxt.phase = PH_HEIGHT;
        end
        PH_HEIGHT: begin
          st_nxt.img_h = num_val;
          st_nxt.phase = PH_MAXVAL;
        end
        PH_MAXVAL: begin
          st_nxt.maxval = num_val;
          res.valid     = 1'b1;
          if (num_val > limit) begin
            st_nxt.phase   = PH_ERROR;
            res.kind       = K_ERROR;
            res.error_code = ERR_MAXVAL;
          end else begin
            res.kind       = K_HEADER;
            res.width      = st.img_w;
            res.height     = st.img_h;
            res.max_sample = num_val;
            res.raw_format = st.raw_mode;
            if (st.img_w == '0 || st.img_h == '0) begin
              res.image_done = 1'b1;
              st_nxt.phase   = PH_DONE;
            end else begin
              st_nxt.phase = st.raw_mode ? PH_RAW : PH_PLAIN;
            end
          end
        end
        PH_PLAIN: begin
          unique case (st.chan)
            CHAN_R: begin
              st_nxt.held_r = num_val;
              st_nxt.chan   = CHAN_G;
            end
            CHAN_G: begin
              st_nxt.held_g = num_val;
              st_nxt.chan   = CHAN_B;
            end
            default: begin
              st_nxt.chan = CHAN_R;
              pix_fire    = 1'b1;
              pix_b       = num_val;
            end
          endcase
        end
        default: ;
      endcase
    end

    // pixel out, advance raster position
    if (pix_fire) begin
      res.valid      = 1'b1;
      res.kind       = K_PIXEL;
      res.red        = st.held_r;
      res.green      = st.held_g;
      res.blue       = pix_b;
      res.column     = st.col;
      res.row_index  = st.row;
      res.raw_format = st.raw_mode;
      if (col_inc >= {1'b0, st.img_w}) begin
        st_nxt.col = '0;
        st_nxt.row = row_inc[NUM_W-1:0];
        if (row_inc >= {1'b0, st.img_h}) begin
          res.image_done = 1'b1;
          st_nxt.phase   = PH_DONE;
        end
      end else begin
        st_nxt.col = col_inc[NUM_W-1:0];
      end
    end
  end

endmodule

// ----- sv/ppm_image_stream_parser_core.sv -----
// Top level of the PPM (P3/P6) byte stream parser.
// Path: a byte goes into the input register, then its result item into the
//   result register.
// Throughput: one byte per cycle while results are taken; a byte that makes a
//   result waits while the result register is full and stalled.
// Reset: rst_n synchronous, active low; parser waits for frame_start, limit = 1023.
`include "ppm_image_stream_parser_core_assert.svh"

module ppm_image_stream_parser_core import ppm_isp_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  ppm_isp_in_if.sink      in_ch,
  ppm_isp_out_if.source   out_ch,
  ppm_isp_cfg_if.sink     cfg_ch
);

  // ---------------------------------------------------------------------
  // Configuration: maxval limit, always writable.
  // ---------------------------------------------------------------------
  logic [NUM_W-1:0] limit_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_ch.valid) begin
      limit_r <= cfg_ch.max_maxval_limit;
    end
  end

  // ---------------------------------------------------------------------
  // Input register. The held byte is parsed when the result slot can take
  // what it makes (bytes with no result never wait on the output side).
  // ---------------------------------------------------------------------
  logic         in_valid_r;
  in_item_t     in_item_r;
  logic         advance;
  logic         in_take;

  parse_state_t st_r;
  parse_state_t st_nxt;
  parse_state_t st_init;
  result_t      res;

  logic         out_valid_r;
  result_t      out_r;

  assign advance     = in_valid_r && (!res.valid || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.in_byte     <= in_ch.in_byte;
      in_item_r.frame_start <= in_ch.frame_start;
      in_item_r.last_byte   <= in_ch.last_byte;
    end
  end

  // ---------------------------------------------------------------------
  // Parse step: next parser state and an optional result item.
  // ---------------------------------------------------------------------
  ppm_isp_step u_step (
    .st     (st_r),
    .item   (in_item_r),
    .limit  (limit_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // reset image: all zero, waiting for frame_start
  always_comb begin
    st_init       = '0;
    st_init.phase = PH_WAIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_init;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result register: holds an item until the sink takes it.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_r.kind;
  assign out_ch.red        = out_r.red;
  assign out_ch.green      = out_r.green;
  assign out_ch.blue       = out_r.blue;
  assign out_ch.column     = out_r.column;
  assign out_ch.row_index  = out_r.row_index;
  assign out_ch.width      = out_r.width;
  assign out_ch.height     = out_r.height;
  assign out_ch.max_sample = out_r.max_sample;
  assign out_ch.raw_format = out_r.raw_format;
  assign out_ch.error_code = out_r.error_code;
  assign out_ch.image_done = out_r.image_done;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // a stalled result is never overwritten
  `PPM_ASSERT_SAME(a_no_overwrite, out_valid_r && !out_ch.ready, !(advance && res.valid))
  // a killed frame stays silent until frame_start
  `PPM_ASSERT_SAME(a_error_silent,
    advance && !in_item_r.frame_start && st_r.phase == PH_ERROR, !res.valid)
  // frame_start always restarts at the second magic byte
  `PPM_ASSERT_NEXT(a_start_magic, advance && in_item_r.frame_start, st_r.phase == PH_MAGIC2)

endmodule
